// ----- rtl/core/rrpm_pkg.sv -----
// Shared types and constants of the rotated rectangle point mapper.
package rrpm_pkg;

    localparam int COORD_W    = 32;
    localparam int TRIG_W     = 18;
    localparam int ISCALE_W   = 24;
    localparam int EXTENT_W   = 31;
    localparam int TEX_W      = 17;
    localparam int NUM_W      = 49;
    localparam int DIV_STAGES = TEX_W;

    localparam logic [TEX_W-1:0] TEX_HALF = 17'd32768;

    typedef enum logic [2:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_COS_YAW       = 3'd2,
        CFG_SIN_YAW       = 3'd3,
        CFG_INVERSE_SCALE = 3'd4,
        CFG_HALF_WIDTH    = 3'd5,
        CFG_HALF_DEPTH    = 3'd6,
        CFG_EDGE_INSET    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        t_cfg_idx    index;
        logic [31:0] value;
    } t_cfg_wr;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [TRIG_W-1:0]  cos_yaw;
        logic signed [TRIG_W-1:0]  sin_yaw;
        logic [ISCALE_W-1:0]       inverse_scale;
        logic [EXTENT_W-1:0]       half_width;
        logic [EXTENT_W-1:0]       half_depth;
        logic [EXTENT_W-1:0]       edge_inset;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        center_x:      32'sd0,
        center_y:      32'sd0,
        cos_yaw:       18'sd65536,
        sin_yaw:       18'sd0,
        inverse_scale: 24'd65536,
        half_width:    31'd65536,
        half_depth:    31'd65536,
        edge_inset:    31'd0
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
    } t_pt;

    // Geometry of one point after the transform, with the tex numerators.
    typedef struct packed {
        logic                      inside_res;
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
        logic signed [COORD_W-1:0] edge_dist_x;
        logic signed [COORD_W-1:0] edge_dist_y;
        logic [NUM_W-1:0]          num_u;
        logic [NUM_W-1:0]          num_v;
    } t_geo;

    typedef struct packed {
        logic                      inside_res;
        logic signed [COORD_W-1:0] local_x;
        logic signed [COORD_W-1:0] local_y;
        logic signed [COORD_W-1:0] edge_dist_x;
        logic signed [COORD_W-1:0] edge_dist_y;
        logic [TEX_W-1:0]          tex_u;
        logic [TEX_W-1:0]          tex_v;
    } t_res;

endpackage

// ----- rtl/core/rrpm_stream_if.sv -----
// Valid/ready channel carrying one payload beat.
interface rrpm_stream_if #(
    parameter type T = logic [0:0]
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/rrpm_cfg_regs.sv -----
// Configuration register file of the point mapper.
module rrpm_cfg_regs
    import rrpm_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    rrpm_stream_if.sink     i_cfg,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.data.index)
                CFG_CENTER_X:      n_cfg.center_x      = i_cfg.data.value;
                CFG_CENTER_Y:      n_cfg.center_y      = i_cfg.data.value;
                CFG_COS_YAW:       n_cfg.cos_yaw       = i_cfg.data.value[TRIG_W-1:0];
                CFG_SIN_YAW:       n_cfg.sin_yaw       = i_cfg.data.value[TRIG_W-1:0];
                CFG_INVERSE_SCALE: n_cfg.inverse_scale = i_cfg.data.value[ISCALE_W-1:0];
                CFG_HALF_WIDTH:    n_cfg.half_width    = i_cfg.data.value[EXTENT_W-1:0];
                CFG_HALF_DEPTH:    n_cfg.half_depth    = i_cfg.data.value[EXTENT_W-1:0];
                CFG_EDGE_INSET:    n_cfg.edge_inset    = i_cfg.data.value[EXTENT_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/rrpm_xform.sv -----
// Six-stage transform: offset, rotate, round, scale, saturate, edge test.
module rrpm_xform
    import rrpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_valid,
    input  t_pt  i_pt,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_geo o_geo
);

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [44:0] v);
        logic signed [COORD_W-1:0] res;
        if (v > 45'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -45'sh0_8000_0000) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

    logic [5:0] r_vld;

    // stage 1: offset from the centre
    logic signed [32:0] r_dx, r_dy;
    // stage 2: the four rotation products
    logic signed [50:0] r_p_cx, r_p_sy, r_p_cy, r_p_sx;
    // stage 3: rotated and rounded to Q16
    logic signed [35:0] r_rx, r_ry;
    // stage 4: scaled
    logic signed [60:0] r_mx, r_my;
    // stage 5: local coordinates
    logic signed [COORD_W-1:0] r_lx, r_ly;
    // stage 6: edge test
    t_geo r_geo;

    logic signed [51:0] w_rx_sum, w_ry_sum;
    logic signed [60:0] w_mx_rnd, w_my_rnd;
    logic signed [32:0] w_ax, w_ay;
    logic signed [32:0] w_ex, w_ey;
    logic signed [32:0] w_inset;
    logic               w_reject;
    logic [33:0]        w_au, w_av;
    t_geo               n_geo;

    always_comb begin
        w_rx_sum = {r_p_cx[50], r_p_cx} + {r_p_sy[50], r_p_sy} + 52'sd32768;
        w_ry_sum = {r_p_cy[50], r_p_cy} - {r_p_sx[50], r_p_sx} + 52'sd32768;
        w_mx_rnd = r_mx + 61'sd32768;
        w_my_rnd = r_my + 61'sd32768;

        w_ax = r_lx[COORD_W-1] ? -{r_lx[COORD_W-1], r_lx} : {r_lx[COORD_W-1], r_lx};
        w_ay = r_ly[COORD_W-1] ? -{r_ly[COORD_W-1], r_ly} : {r_ly[COORD_W-1], r_ly};
        w_ex = $signed({2'b00, i_cfg.half_width}) - w_ax;
        w_ey = $signed({2'b00, i_cfg.half_depth}) - w_ay;
        w_inset = $signed({2'b00, i_cfg.edge_inset});
        w_reject = w_ex[32] || w_ey[32] ||
                   ((i_cfg.edge_inset != '0) && (w_ex <= w_inset || w_ey <= w_inset));

        // local + half is in [0, 2*half] whenever the point is kept
        w_au = {{2{r_lx[COORD_W-1]}}, r_lx} + {3'b000, i_cfg.half_width};
        w_av = {{2{r_ly[COORD_W-1]}}, r_ly} + {3'b000, i_cfg.half_depth};

        n_geo.inside_res  = !w_reject;
        n_geo.local_x     = w_reject ? '0 : r_lx;
        n_geo.local_y     = w_reject ? '0 : r_ly;
        n_geo.edge_dist_x = w_reject ? '0 : w_ex[COORD_W-1:0];
        n_geo.edge_dist_y = w_reject ? '0 : w_ey[COORD_W-1:0];
        n_geo.num_u = {1'b0, w_au[31:0], 16'h0000} + {18'd0, i_cfg.half_width};
        n_geo.num_v = {1'b0, w_av[31:0], 16'h0000} + {18'd0, i_cfg.half_depth};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_dx   <= {i_pt.pos_x[31], i_pt.pos_x} - {i_cfg.center_x[31], i_cfg.center_x};
            r_dy   <= {i_pt.pos_y[31], i_pt.pos_y} - {i_cfg.center_y[31], i_cfg.center_y};
            r_p_cx <= i_cfg.cos_yaw * r_dx;
            r_p_sy <= i_cfg.sin_yaw * r_dy;
            r_p_cy <= i_cfg.cos_yaw * r_dy;
            r_p_sx <= i_cfg.sin_yaw * r_dx;
            r_rx   <= w_rx_sum[51:16];
            r_ry   <= w_ry_sum[51:16];
            r_mx   <= r_rx * $signed({1'b0, i_cfg.inverse_scale});
            r_my   <= r_ry * $signed({1'b0, i_cfg.inverse_scale});
            r_lx   <= sat32(w_mx_rnd[60:16]);
            r_ly   <= sat32(w_my_rnd[60:16]);
            r_geo  <= n_geo;
        end
    end

    assign o_valid = r_vld[5];
    assign o_geo   = r_geo;

endmodule

// ----- rtl/core/rrpm_tex_div.sv -----
// Pipelined restoring divider for tex u and v, one quotient bit per stage.
module rrpm_tex_div
    import rrpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  logic i_valid,
    input  t_geo i_geo,
    input  t_cfg i_cfg,
    output logic o_valid,
    output t_res o_res
);

    logic [DIV_STAGES-1:0] r_vld;
    t_geo                  r_geo   [DIV_STAGES];
    logic [NUM_W-1:0]      r_rem_u [DIV_STAGES];
    logic [NUM_W-1:0]      r_rem_v [DIV_STAGES];
    logic [TEX_W-1:0]      r_q_u   [DIV_STAGES];
    logic [TEX_W-1:0]      r_q_v   [DIV_STAGES];

    logic [31:0] w_den_u, w_den_v;

    assign w_den_u = {i_cfg.half_width, 1'b0};
    assign w_den_v = {i_cfg.half_depth, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_valid};
        end
    end

    for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
        localparam int K = DIV_STAGES - 1 - i;

        t_geo             w_geo;
        logic [NUM_W-1:0] w_rem_u, w_rem_v;
        logic [TEX_W-1:0] w_q_u, w_q_v;
        logic [NUM_W:0]   w_try_u, w_try_v;

        if (i == 0) begin : g_first
            assign w_geo   = i_geo;
            assign w_rem_u = i_geo.num_u;
            assign w_rem_v = i_geo.num_v;
            assign w_q_u   = '0;
            assign w_q_v   = '0;
        end else begin : g_next
            assign w_geo   = r_geo[i-1];
            assign w_rem_u = r_rem_u[i-1];
            assign w_rem_v = r_rem_v[i-1];
            assign w_q_u   = r_q_u[i-1];
            assign w_q_v   = r_q_v[i-1];
        end

        // borrow out of the top bit means the shifted divisor does not fit
        assign w_try_u = {1'b0, w_rem_u} - ({18'd0, w_den_u} << K);
        assign w_try_v = {1'b0, w_rem_v} - ({18'd0, w_den_v} << K);

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_geo[i]   <= w_geo;
                r_rem_u[i] <= w_try_u[NUM_W] ? w_rem_u : w_try_u[NUM_W-1:0];
                r_rem_v[i] <= w_try_v[NUM_W] ? w_rem_v : w_try_v[NUM_W-1:0];
                r_q_u[i]   <= w_q_u | ({{(TEX_W-1){1'b0}}, !w_try_u[NUM_W]} << K);
                r_q_v[i]   <= w_q_v | ({{(TEX_W-1){1'b0}}, !w_try_v[NUM_W]} << K);
            end
        end
    end

    t_geo w_last;
    assign w_last = r_geo[DIV_STAGES-1];

    always_comb begin
        o_res.inside_res  = w_last.inside_res;
        o_res.local_x     = w_last.local_x;
        o_res.local_y     = w_last.local_y;
        o_res.edge_dist_x = w_last.edge_dist_x;
        o_res.edge_dist_y = w_last.edge_dist_y;
        // a zero extent keeps only the centre line, which maps to one half
        if (!w_last.inside_res) begin
            o_res.tex_u = '0;
            o_res.tex_v = '0;
        end else begin
            o_res.tex_u = (i_cfg.half_width == '0) ? TEX_HALF : r_q_u[DIV_STAGES-1];
            o_res.tex_v = (i_cfg.half_depth == '0) ? TEX_HALF : r_q_v[DIV_STAGES-1];
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];

endmodule

// ----- rtl/core/rotated_rect_point_mapper_top.sv -----
// Top level of the rotated rectangle point mapper.
//
//  port    dir  beat     payload
//  i_cfg   in   t_cfg_wr register index and value, always ready
//  i_pt    in   t_pt     world point pos_x, pos_y
//  o_res   out  t_res    inside flag, local coords, edge distances, tex u/v
//
// One point per cycle while the skid register is empty; an accepted point passes
// through 6 transform stages, 17 divider stages and 1 output register.
// The divider depth is set by the 17-bit tex quotient, one bit per stage.
// Reset is synchronous, active low, and clears only valid bits and the config.
// A stalled result moves into a skid register; the pipeline halts only while it is full.
module rotated_rect_point_mapper_top
    import rrpm_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    rrpm_stream_if.sink   i_cfg,
    rrpm_stream_if.sink   i_pt,
    rrpm_stream_if.source o_res
);

    t_cfg w_cfg;
    logic w_adv;
    logic w_x_valid;
    t_geo w_x_geo;
    logic w_p_valid;
    t_res w_p_res;

    logic r_out_valid;
    t_res r_out;
    logic r_skid_valid;
    t_res r_skid;

    assign w_adv      = !r_skid_valid;
    assign i_pt.ready = w_adv;

    rrpm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rrpm_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_pt.valid),
        .i_pt    (i_pt.data),
        .i_cfg   (w_cfg),
        .o_valid (w_x_valid),
        .o_geo   (w_x_geo)
    );

    rrpm_tex_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_x_valid),
        .i_geo   (w_x_geo),
        .i_cfg   (w_cfg),
        .o_valid (w_p_valid),
        .o_res   (w_p_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_res.ready) begin
            r_out_valid  <= r_skid_valid || w_p_valid;
            r_skid_valid <= 1'b0;
        end else if (w_p_valid && w_adv) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_res.ready) begin
            r_out <= r_skid_valid ? r_skid : w_p_res;
        end else if (w_p_valid && w_adv) begin
            r_skid <= w_p_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a beat while the output register is empty");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pt.ready |-> (r_out_valid && $past(r_out_valid && !o_res.ready)))
        else $error("input stalled without a blocked result");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.inside_res) |->
        (o_res.data.local_x == '0 && o_res.data.local_y == '0 &&
         o_res.data.tex_u == '0 && o_res.data.tex_v == '0))
        else $error("rejected point carries nonzero fields");

    a_tex_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.data.inside_res) |->
        (o_res.data.tex_u <= 17'd65536 && o_res.data.tex_v <= 17'd65536))
        else $error("tex coordinate beyond one");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the rotated rectangle point mapper top level.
`timescale 1ns / 1ps

module testbench;

    import rrpm_pkg::*;

    class rect_map_tracker;
        t_cfg regs;
        t_res pending_maps[$];
        int   mismatches;

        function new();
            regs       = CFG_RESET;
            mismatches = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_CENTER_X:      regs.center_x      = value;
                CFG_CENTER_Y:      regs.center_y      = value;
                CFG_COS_YAW:       regs.cos_yaw       = value[TRIG_W-1:0];
                CFG_SIN_YAW:       regs.sin_yaw       = value[TRIG_W-1:0];
                CFG_INVERSE_SCALE: regs.inverse_scale = value[ISCALE_W-1:0];
                CFG_HALF_WIDTH:    regs.half_width    = value[EXTENT_W-1:0];
                CFG_HALF_DEPTH:    regs.half_depth    = value[EXTENT_W-1:0];
                CFG_EDGE_INSET:    regs.edge_inset    = value[EXTENT_W-1:0];
                default: ;
            endcase
        endfunction

        // Round half up to 16 fraction bits; >>> on longint floors.
        function longint round_q16(longint v);
            return (v + 64'sd32768) >>> 16;
        endfunction

        function longint to_local(longint rot);
            longint r;
            r = round_q16(round_q16(rot) * longint'(regs.inverse_scale));
            if (r > 64'sd2147483647)
                r = 64'sd2147483647;
            if (r < -64'sd2147483648)
                r = -64'sd2147483648;
            return r;
        endfunction

        function logic [TEX_W-1:0] to_tex(longint loc, longint half);
            if (half == 0)
                return TEX_HALF;
            return TEX_W'(((loc + half) * 65536 + half) / (2 * half));
        endfunction

        function void note_point(t_pt p);
            longint dx, dy, c, s, lx, ly, ex, ey, hw, hd, inset;
            t_res   r;
            dx    = longint'(p.pos_x) - longint'(regs.center_x);
            dy    = longint'(p.pos_y) - longint'(regs.center_y);
            c     = longint'(regs.cos_yaw);
            s     = longint'(regs.sin_yaw);
            hw    = longint'(regs.half_width);
            hd    = longint'(regs.half_depth);
            inset = longint'(regs.edge_inset);
            lx    = to_local(c * dx + s * dy);
            ly    = to_local(c * dy - s * dx);
            ex    = hw - (lx < 0 ? -lx : lx);
            ey    = hd - (ly < 0 ? -ly : ly);
            r     = '0;
            if (!(ex < 0 || ey < 0 || (inset > 0 && (ex <= inset || ey <= inset)))) begin
                r.inside_res  = 1'b1;
                r.local_x     = lx[31:0];
                r.local_y     = ly[31:0];
                r.edge_dist_x = ex[31:0];
                r.edge_dist_y = ey[31:0];
                r.tex_u       = to_tex(lx, hw);
                r.tex_v       = to_tex(ly, hd);
            end
            pending_maps.push_back(r);
        endfunction

        function void check_field(string name, longint want, longint got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_map(t_res got);
            t_res want;
            if (pending_maps.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
                return;
            end
            want = pending_maps.pop_front();
            check_field("inside_res", want.inside_res, got.inside_res);
            check_field("local_x", want.local_x, got.local_x);
            check_field("local_y", want.local_y, got.local_y);
            check_field("edge_dist_x", want.edge_dist_x, got.edge_dist_x);
            check_field("edge_dist_y", want.edge_dist_y, got.edge_dist_y);
            check_field("tex_u", want.tex_u, got.tex_u);
            check_field("tex_v", want.tex_v, got.tex_v);
        endfunction

        function int pending();
            return pending_maps.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rrpm_stream_if #(.T(t_cfg_wr)) cfg_if ();
    rrpm_stream_if #(.T(t_pt))     pt_if ();
    rrpm_stream_if #(.T(t_res))    res_if ();

    rect_map_tracker tracker;
    bit calm         = 1'b0;
    int backlog_req  = 0;
    int backlog_done = 0;

    rotated_rect_point_mapper_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pt    (pt_if),
        .o_res   (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off on request to back up the pipe.
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (backlog_req != backlog_done) begin
                backlog_done = backlog_req;
                res_if.ready <= 1'b0;
                repeat (300) @(posedge i_clk);
            end
            res_if.ready <= calm || ($urandom_range(99) >= 19);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pt_if.valid && pt_if.ready)
                tracker.note_point(pt_if.data);
            if (res_if.valid && res_if.ready)
                tracker.check_map(res_if.data);
        end
    end

    task automatic send_point(input logic [31:0] x, input logic [31:0] y);
        t_pt p;
        p.pos_x = x;
        p.pos_y = y;
        // Insert idle cycles at random so about a fifth of the cycles go empty.
        while (!calm && $urandom_range(99) < 19) begin
            pt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data  <= p;
        do @(posedge i_clk); while (!pt_if.ready);
    endtask

    // Drop valid and wait until every mapped point has come back.
    task automatic settle();
        pt_if.valid <= 1'b0;
        // Let the monitor note the last accepted beat first.
        @(posedge i_clk);
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [31:0] cx, input logic [31:0] cy,
                                input logic [31:0] cs, input logic [31:0] sn,
                                input logic [31:0] isc, input logic [31:0] hw,
                                input logic [31:0] hd, input logic [31:0] ins);
        logic [31:0] vals [8];
        logic [31:0] mask;
        logic [31:0] v;
        int          w;
        vals = '{cx, cy, cs, sn, isc, hw, hd, ins};
        for (int i = 0; i < 8; i++) begin
            case (t_cfg_idx'(i))
                CFG_CENTER_X, CFG_CENTER_Y:     w = COORD_W;
                CFG_COS_YAW, CFG_SIN_YAW:       w = TRIG_W;
                CFG_INVERSE_SCALE:              w = ISCALE_W;
                default:                        w = EXTENT_W;
            endcase
            // Fill bits above the register width with junk; the block must drop them.
            mask = (32'd1 << w) - 32'd1;
            v    = (vals[i] & mask) | ($urandom & ~mask);
            cfg_if.valid <= 1'b1;
            cfg_if.data  <= '{index: t_cfg_idx'(i), value: v};
            do @(posedge i_clk); while (!cfg_if.ready);
            tracker.set_reg(t_cfg_idx'(i), v);
        end
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_trig();
        case ($urandom_range(9))
            0:       return 32'd65536;
            1:       return -32'sd65536;
            2:       return $urandom;
            default: return 32'($urandom_range(0, 131072)) - 32'd65536;
        endcase
    endfunction

    function automatic logic [31:0] pick_extent();
        if ($urandom_range(4) == 0)
            return $urandom_range(1, 32'h7fff_ffff);
        return $urandom_range(256, 32'h0100_0000);
    endfunction

    task automatic random_regs();
        logic [31:0] hw, hd, isc, ins;
        hw  = pick_extent();
        hd  = pick_extent();
        isc = ($urandom_range(3) == 0) ? $urandom_range(1, 32'hff_ffff)
                                       : $urandom_range(16384, 262144);
        ins = ($urandom_range(1) == 0) ? 32'd0
                                       : $urandom_range(0, ((hw < hd) ? hw : hd) / 4);
        program_regs($urandom, $urandom, pick_trig(), pick_trig(), isc, hw, hd, ins);
    endtask

    // Mostly points around the centre, scaled so a fair share lands inside.
    task automatic random_points(input int count, input int hold_at);
        longint      spread, lim, off_x, off_y;
        logic [31:0] x, y;
        lim = (tracker.regs.half_width < tracker.regs.half_depth) ?
              longint'(tracker.regs.half_width) : longint'(tracker.regs.half_depth);
        if (tracker.regs.inverse_scale == 0)
            spread = 64'sd2147483647;
        else
            spread = lim * 65536 / longint'(tracker.regs.inverse_scale);
        if (spread < 1)
            spread = 1;
        if (spread > 64'sd2147483647)
            spread = 64'sd2147483647;
        for (int k = 0; k < count; k++) begin
            if (k == hold_at)
                backlog_req++;
            case ($urandom_range(9))
                0, 1: begin
                    x = $urandom;
                    y = $urandom;
                end
                2: begin
                    x = ($urandom_range(1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
                    y = ($urandom_range(1) == 0) ? tracker.regs.center_y : $urandom;
                end
                default: begin
                    off_x = longint'($urandom_range(0, 32'(2 * spread))) - spread;
                    off_y = longint'($urandom_range(0, 32'(2 * spread))) - spread;
                    x = 32'(longint'(tracker.regs.center_x) + off_x);
                    y = 32'(longint'(tracker.regs.center_y) + off_y);
                end
            endcase
            send_point(x, y);
        end
    endtask

    initial begin
        tracker = new();
        i_rst_n      <= 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.data  <= '0;
        pt_if.valid  <= 1'b0;
        pt_if.data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset geometry: square of half extent one at the origin.
        send_point(32'd0, 32'd0);
        send_point(32'd65536, 32'd0);
        send_point(32'd65537, 32'd0);
        send_point(-32'sd65536, 32'd65536);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);

        // Largest centre offset, trig beyond unit range, max scale: locals saturate.
        settle();
        program_regs(32'h8000_0000, 32'h8000_0000, 32'h0001_ffff, 32'hfffe_0000,
                     32'h00ff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'd0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff);
        send_point(32'h8000_0000, 32'h8000_0000);
        send_point(32'h7fff_ffff, 32'h8000_0000);

        // Zero half extents with the smallest scale: only a zero local passes.
        settle();
        program_regs(32'd12345, -32'sd777, -32'sd65536, 32'd65536,
                     32'd1, 32'd0, 32'd0, 32'd0);
        send_point(32'd12345, -32'sd777);
        send_point(32'd32345, -32'sd777);
        send_point(32'h7fff_ffff, 32'h8000_0000);

        // Edge inset: a distance equal to the inset is rejected.
        settle();
        program_regs(32'd0, 32'd0, 32'd65536, 32'd0,
                     32'd65536, 32'd65536, 32'd131072, 32'd16384);
        send_point(32'd49152, 32'd0);
        send_point(32'd49151, 32'd0);
        send_point(32'd0, 32'd114688);
        send_point(-32'sd49151, -32'sd114687);

        // Zero scale collapses every point onto the centre.
        settle();
        program_regs(32'h7fff_ffff, 32'h8000_0000, 32'hfffe_0000, 32'h0001_ffff,
                     32'd0, 32'd0, 32'd0, 32'd0);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'd0, 32'd0);

        for (int ph = 0; ph < 7; ph++) begin
            settle();
            random_regs();
            calm = (ph == 2);
            random_points(250, (ph == 4) ? 100 : -1);
        end
        calm = 1'b0;
        settle();

        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
